@@ hdl/rsa_modular_exponentiation_core_macros.svh @@
// Assertion macros shared by the exponentiation core.
// Expects signals named clk and arst_n in the including module.
`ifndef RSA_MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSA_ASSERT_HOLD(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/rsa_pkg.sv @@
// Package for the modular exponentiation core: state type, codes and fixed widths.
// Has no dependencies; imported by rsa_modular_exponentiation_core.
`timescale 1ns / 1ps

package rsa_pkg;

	// Width of the value, result and configuration fields.
	localparam int FIELD_BITS = 31;
	// Bits of the base scanned during the initial reduction.
	localparam int BASE_BITS  = 31;
	// Bits kept from a byte (encrypt base, decrypt result).
	localparam int BYTE_BITS  = 8;
	// Bit counter width, enough to count 0 .. 30.
	localparam int CNT_W      = 5;

	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	localparam logic [1:0] REG_MODULUS  = 2'd0;
	localparam logic [1:0] REG_ENC_EXP  = 2'd1;
	localparam logic [1:0] REG_DEC_EXP  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MULT,
		ST_SQUARE,
		ST_DONE
	} state_t;

endpackage

@@ hdl/rsa_modular_exponentiation_core.sv @@
// Modular exponentiation core: bit-serial square-and-multiply with an APB register port.
// Depends on rsa_pkg and rsa_modular_exponentiation_core_macros.svh.
`timescale 1ns / 1ps
`include "rsa_modular_exponentiation_core_macros.svh"

// Usage
// Registers (APB, always ready): modulus at 0x0, encrypt exponent at 0x4, decrypt
// exponent at 0x8, each 31 bits and reset to 1. Only the low MODULUS_WIDTH bits of
// the modulus are used; a modulus of zero acts as one. Write them while busy is low.
// An item (action, value) is taken at a clock edge with start high and busy low.
// Encrypt raises the low byte of value to the encrypt exponent; decrypt raises the
// whole value to the decrypt exponent and keeps the low byte of the residue.
// The result appears on result with done high for exactly one cycle; there is no
// back-pressure, the receiver must take it then. busy drops in that same cycle, so
// the next item may be taken at the edge that ends it.
// A zero exponent gives 1. One modular multiply runs in a shared shift-and-add unit,
// one multiplier bit per cycle, and the base is first reduced one bit per cycle over
// its 31 bits. Items are processed one at a time.
// Reset (arst_n low) returns to idle and restores the register reset values.
module rsa_modular_exponentiation_core #(
	parameter int MODULUS_WIDTH = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [30:0] value,
	output logic        done,
	output logic [30:0] result
);

	import rsa_pkg::*;

	localparam int W  = MODULUS_WIDTH;
	localparam int SW = W + 2;

	state_t state_q, state_d;

	logic [FIELD_BITS-1:0] mod_q, eexp_q, dexp_q;
	logic [FIELD_BITS-1:0] exp_q;
	logic [BASE_BITS-1:0]  base_q;
	logic [W-1:0]          m_eff;
	logic [W-1:0]          p_q, acc_q, sq_q, mb_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  act_q;
	logic [FIELD_BITS-1:0] result_q;
	logic                  done_q;

	logic                  accept;
	logic                  cfg_wr;
	logic [FIELD_BITS-1:0] exp_sel;
	logic                  exp_more;
	logic                  cnt_last;

	logic [SW-1:0] addend_w, sum_w;
	logic [SW:0]   t1_w, t2_w;
	logic [W-1:0]  red_w;

	// Controls from the output decoder.
	logic run, enter_op, mb_sel_acc, exp_shift_en;
	logic fin_reduce, fin_mult, fin_square, fin_done;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start & ~busy;
	assign exp_sel  = (action == ACT_DECRYPT) ? dexp_q : eexp_q;
	assign exp_more = |exp_q[FIELD_BITS-1:1];
	assign m_eff    = (mod_q[W-1:0] == '0) ? W'(1) : mod_q[W-1:0];
	assign cnt_last = (state_q == ST_REDUCE) ? (cnt_q == CNT_W'(BASE_BITS - 1))
	                                         : (cnt_q == CNT_W'(W - 1));

	// One step of the shift-and-add unit: 2p + addend, then reduce from below 3m.
	always_comb begin
		if (state_q == ST_REDUCE) begin
			addend_w = SW'(base_q[BASE_BITS-1]);
		end else if (mb_q[W-1]) begin
			addend_w = {2'b00, sq_q};
		end else begin
			addend_w = '0;
		end
		sum_w = {1'b0, p_q, 1'b0} + addend_w;
		t1_w  = {1'b0, sum_w} - {3'b000, m_eff};
		t2_w  = {1'b0, sum_w} - {2'b00, m_eff, 1'b0};
		if (!t2_w[SW]) begin
			red_w = t2_w[W-1:0];
		end else if (!t1_w[SW]) begin
			red_w = t1_w[W-1:0];
		end else begin
			red_w = sum_w[W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (exp_sel == '0) ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (cnt_last) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (exp_q[0]) begin
					state_d = ST_MULT;
				end else begin
					state_d = exp_more ? ST_SQUARE : ST_DONE;
				end
			end
			ST_MULT: begin
				if (cnt_last) begin
					state_d = exp_more ? ST_SQUARE : ST_DONE;
				end
			end
			ST_SQUARE: begin
				if (cnt_last) begin
					state_d = ST_STEP;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath controls.
	always_comb begin
		run          = 1'b0;
		enter_op     = 1'b0;
		mb_sel_acc   = 1'b0;
		exp_shift_en = 1'b0;
		fin_reduce   = 1'b0;
		fin_mult     = 1'b0;
		fin_square   = 1'b0;
		fin_done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_REDUCE: begin
				run        = 1'b1;
				fin_reduce = cnt_last;
			end
			ST_STEP: begin
				if (exp_q[0]) begin
					enter_op   = 1'b1;
					mb_sel_acc = 1'b1;
				end else begin
					exp_shift_en = 1'b1;
					enter_op     = exp_more;
				end
			end
			ST_MULT: begin
				run = 1'b1;
				if (cnt_last) begin
					fin_mult     = 1'b1;
					exp_shift_en = 1'b1;
					enter_op     = exp_more;
				end
			end
			ST_SQUARE: begin
				run        = 1'b1;
				fin_square = cnt_last;
			end
			ST_DONE: begin
				fin_done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			mod_q   <= FIELD_BITS'(1);
			eexp_q  <= FIELD_BITS'(1);
			dexp_q  <= FIELD_BITS'(1);
		end else begin
			state_q <= state_d;
			done_q  <= fin_done;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_MODULUS: mod_q  <= pwdata[FIELD_BITS-1:0];
					REG_ENC_EXP: eexp_q <= pwdata[FIELD_BITS-1:0];
					REG_DEC_EXP: dexp_q <= pwdata[FIELD_BITS-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers; later assignments take priority.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			exp_q  <= exp_sel;
			base_q <= (action == ACT_DECRYPT) ? value : BASE_BITS'(value[BYTE_BITS-1:0]);
			p_q    <= '0;
			cnt_q  <= '0;
			acc_q  <= W'(1);
		end
		if (run) begin
			p_q   <= red_w;
			cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == ST_REDUCE) begin
				base_q <= {base_q[BASE_BITS-2:0], 1'b0};
			end else begin
				mb_q <= {mb_q[W-2:0], 1'b0};
			end
		end
		if (fin_reduce) begin
			sq_q  <= red_w;
			acc_q <= (m_eff == W'(1)) ? W'(0) : W'(1);
		end
		if (fin_mult) begin
			acc_q <= red_w;
		end
		if (fin_square) begin
			sq_q <= red_w;
		end
		if (exp_shift_en) begin
			exp_q <= {1'b0, exp_q[FIELD_BITS-1:1]};
		end
		if (enter_op) begin
			p_q   <= '0;
			cnt_q <= '0;
			mb_q  <= mb_sel_acc ? acc_q : sq_q;
		end
		if (fin_done) begin
			result_q <= (act_q == ACT_DECRYPT) ? FIELD_BITS'(acc_q[BYTE_BITS-1:0])
			                                   : FIELD_BITS'(acc_q);
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODULUS: prdata = {1'b0, mod_q};
			REG_ENC_EXP: prdata = {1'b0, eexp_q};
			REG_DEC_EXP: prdata = {1'b0, dexp_q};
			default:     prdata = '0;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	`RSA_ASSERT_NEXT(a_accept_busy, accept, busy, "core not busy after taking an item")
	`RSA_ASSERT_NEXT(a_done_strobe, state_q == ST_DONE, done_q && !busy, "missing result strobe")
	`RSA_ASSERT_HOLD(a_cnt_range, (state_q == ST_MULT) || (state_q == ST_SQUARE), cnt_q <= CNT_W'(W - 1), "multiply bit counter overran")
	`RSA_ASSERT_HOLD(a_dec_byte, done_q && (act_q == ACT_DECRYPT), result_q[FIELD_BITS-1:BYTE_BITS] == '0, "decrypt result wider than a byte")

endmodule

@@ sim/rsa_modexp_checker.sv @@
// Checker for the modular exponentiation core: tracks register writes, predicts
// each residue at the accepting edge and compares it with the done strobe.
// Depends on rsa_pkg; instantiated beside the core by tb_rsa_modular_exponentiation_core.
`timescale 1ns / 1ps

module rsa_modexp_checker
	import rsa_pkg::*;
#(
	parameter int MODULUS_WIDTH = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic        action,
	input  logic [30:0] value,
	input  logic        done,
	input  logic [30:0] result,
	output int          mismatch_count,
	output int          residues_pending
);

	logic [30:0] modulus_reg;
	logic [30:0] enc_exp_reg;
	logic [30:0] dec_exp_reg;
	logic [30:0] expected_residues[$];

	function automatic longint unsigned raise_mod(longint unsigned base_v,
			longint unsigned expo, longint unsigned m);
		longint unsigned acc;
		longint unsigned sq;
		if (expo == 0)
			return 1;
		sq = base_v % m;
		acc = 1 % m;
		while (expo != 0) begin
			if ((expo & 1) != 0)
				acc = (acc * sq) % m;
			expo = expo >> 1;
			sq = (sq * sq) % m;
		end
		return acc;
	endfunction

	function automatic logic [30:0] residue_for(logic act, logic [30:0] val);
		longint unsigned m;
		longint unsigned r;
		m = longint'(modulus_reg) & ((64'd1 << MODULUS_WIDTH) - 1);
		// A modulus of zero behaves as a modulus of one.
		if (m == 0)
			m = 1;
		if (act == ACT_ENCRYPT) begin
			r = raise_mod(longint'(val[7:0]), longint'(enc_exp_reg), m);
		end else begin
			r = raise_mod(longint'(val), longint'(dec_exp_reg), m) & 64'hFF;
		end
		return r[30:0];
	endfunction

	task automatic note_mismatch(string what, logic [30:0] want, logic [30:0] got);
		if (mismatch_count < 10)
			$display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $realtime, what,
				want, got);
		mismatch_count++;
	endtask

	initial begin
		mismatch_count = 0;
		residues_pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		logic [30:0] want;
		if (!arst_n) begin
			modulus_reg <= 31'd1;
			enc_exp_reg <= 31'd1;
			dec_exp_reg <= 31'd1;
			expected_residues.delete();
			residues_pending = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_MODULUS: modulus_reg <= pwdata[30:0];
						REG_ENC_EXP: enc_exp_reg <= pwdata[30:0];
						REG_DEC_EXP: dec_exp_reg <= pwdata[30:0];
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						REG_MODULUS: want = modulus_reg;
						REG_ENC_EXP: want = enc_exp_reg;
						REG_DEC_EXP: want = dec_exp_reg;
						default: want = prdata[30:0];
					endcase
					if (prdata[30:0] !== want)
						note_mismatch("register read", want, prdata[30:0]);
				end
			end
			if (start && !busy)
				expected_residues.push_back(residue_for(action, value));
			if (done) begin
				if (expected_residues.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result 0x%08h with no item outstanding", $realtime,
							result);
					mismatch_count++;
				end else begin
					want = expected_residues.pop_front();
					if (result !== want)
						note_mismatch("result", want, result);
				end
			end
			residues_pending = expected_residues.size();
		end
	end

endmodule

@@ sim/tb_rsa_modular_exponentiation_core.sv @@
// Top of the exponentiation core testbench: clock, reset, register setup and items.
// Depends on rsa_pkg, rsa_modular_exponentiation_core and rsa_modexp_checker.
`timescale 1ns / 1ps

module tb_rsa_modular_exponentiation_core;
	import rsa_pkg::*;

	localparam int MOD_W = 31;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic        action;
	logic [30:0] value;
	logic        done;
	logic [30:0] result;
	int          mismatch_count;
	int          residues_pending;
	int          items_sent;
	bit          back_to_back;

	rsa_modular_exponentiation_core #(.MODULUS_WIDTH(MOD_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .action(action), .value(value),
		.done(done), .result(result)
	);

	rsa_modexp_checker #(.MODULUS_WIDTH(MOD_W)) chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .action(action), .value(value),
		.done(done), .result(result),
		.mismatch_count(mismatch_count), .residues_pending(residues_pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// All tasks below start and end at a falling edge.
	task automatic send_item(input logic act, input logic [30:0] val);
		int gap;
		start <= 1'b1;
		action <= act;
		value <= val;
		do @(posedge clk); while (busy);
		@(negedge clk);
		gap = back_to_back ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_sent++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (residues_pending != 0 || busy)
			@(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [30:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		// Bit 31 is not part of any register and must be ignored.
		pwdata <= {1'($urandom_range(0, 1)), val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		apb_access(1'b1, idx, val);
	endtask

	task automatic read_reg(input logic [1:0] idx);
		apb_access(1'b0, idx, 31'($urandom));
	endtask

	function automatic logic [30:0] pick_modulus();
		case ($urandom_range(0, 9))
			0: return 31'd0;
			1: return 31'd1;
			2: return 31'd2;
			3: return 31'h7FFFFFFF;
			4: return 31'($urandom_range(3, 300));
			5: return 31'($urandom_range(256, 65535));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic [30:0] pick_exponent();
		case ($urandom_range(0, 9))
			0: return 31'd0;
			1: return 31'd1;
			2: return 31'd65537;
			3: return 31'h7FFFFFFF;
			4: return 31'($urandom_range(2, 255));
			5: return 31'($urandom_range(256, 65535));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic [30:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 31'd0;
			1: return 31'h7FFFFFFF;
			2: return 31'($urandom_range(0, 255));
			3: return 31'($urandom_range(1, 3));
			default: return 31'($urandom);
		endcase
	endfunction

	initial begin
		int n_items;
		int timeout;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		action = ACT_ENCRYPT;
		value = '0;
		arst_n = 1'b0;
		items_sent = 0;
		back_to_back = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: modulus one, both exponents one.
		read_reg(REG_MODULUS);
		read_reg(REG_ENC_EXP);
		read_reg(REG_DEC_EXP);
		send_item(ACT_ENCRYPT, 31'h7FFFFFFF);
		send_item(ACT_DECRYPT, 31'h7FFFFFFF);

		wait_idle();
		write_reg(REG_MODULUS, 31'h7FFFFFFF);
		write_reg(REG_ENC_EXP, 31'd65537);
		write_reg(REG_DEC_EXP, 31'h7FFFFFFF);
		read_reg(REG_DEC_EXP);
		send_item(ACT_ENCRYPT, 31'h000000FF);
		send_item(ACT_ENCRYPT, 31'h7FFFFF00);
		send_item(ACT_DECRYPT, 31'h7FFFFFFF);
		send_item(ACT_DECRYPT, 31'd0);
		send_item(ACT_DECRYPT, 31'd1);
		send_item(ACT_ENCRYPT, 31'd2);

		// Zero exponents give one even with a modulus of one.
		wait_idle();
		write_reg(REG_MODULUS, 31'd1);
		write_reg(REG_ENC_EXP, 31'd0);
		write_reg(REG_DEC_EXP, 31'd0);
		send_item(ACT_ENCRYPT, 31'd5);
		send_item(ACT_DECRYPT, 31'd0);
		send_item(ACT_DECRYPT, 31'h7FFFFFFF);

		// A zero modulus acts as one.
		wait_idle();
		write_reg(REG_MODULUS, 31'd0);
		write_reg(REG_ENC_EXP, 31'd3);
		write_reg(REG_DEC_EXP, 31'h7FFFFFFF);
		read_reg(REG_MODULUS);
		send_item(ACT_ENCRYPT, 31'd7);
		send_item(ACT_DECRYPT, 31'd12345);

		// Textbook key pair: 61 * 53 with exponents 17 and 2753.
		wait_idle();
		write_reg(REG_MODULUS, 31'd3233);
		write_reg(REG_ENC_EXP, 31'd17);
		write_reg(REG_DEC_EXP, 31'd2753);
		send_item(ACT_ENCRYPT, 31'd65);
		send_item(ACT_DECRYPT, 31'd2790);
		send_item(ACT_DECRYPT, 31'd3232);
		send_item(ACT_DECRYPT, 31'd3233);

		while (items_sent < 275) begin
			wait_idle();
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_MODULUS, pick_modulus());
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_ENC_EXP, pick_exponent());
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_DEC_EXP, pick_exponent());
			if ($urandom_range(0, 3) == 0)
				read_reg(2'($urandom_range(0, 2)));
			back_to_back = ($urandom_range(0, 3) == 0);
			n_items = $urandom_range(8, 30);
			repeat (n_items)
				send_item(1'($urandom_range(0, 1)), pick_value());
			back_to_back = 1'b0;
		end

		start <= 1'b0;
		timeout = 0;
		while (residues_pending != 0 && timeout < 5000) begin
			@(negedge clk);
			timeout++;
		end
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && residues_pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Worst case is about 305 items at full exponent length; this allows several times their run time.
	initial begin
		#6000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
